// ===== hdl/lnes_pkg.sv =====
// ----------------------------------------------------------------------------
// Looping note event scheduler package
// Shared types and constants: operation codes, register indexes, field widths
// and the sequencer state type.
// ----------------------------------------------------------------------------
package lnes_pkg;

   localparam int OP_W       = 2;
   localparam int ELAPSED_W  = 20;
   localparam int INDEX_W    = 5;
   localparam int TIME_MS_W  = 20;
   localparam int MSG_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam int CNT_W      = 6;
   localparam int BPM_W      = 10;
   localparam int POS_W      = 32;
   localparam int TIME_US_W  = 30;
   localparam int PROD_W     = ELAPSED_W + BPM_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int DIV_CNT_W  = 5;
   localparam int US_PER_MS  = 1000;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGINAL_BPM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_BPM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_OVR    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SUM,
      ST_SETUP,
      ST_SCAN,
      ST_FLUSH
   } lnes_state_type;

endpackage

// ===== hdl/lnes_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and held
// while no read is requested.
// ----------------------------------------------------------------------------
module lnes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/looping_note_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// Looping note event scheduler
// Plays a table of timestamped three-byte note messages in a loop, driven by
// start, stop, load and tick beats.
// ----------------------------------------------------------------------------
// Start, stop and load beats complete in the cycle they are accepted, as does
// a tick while stopped. A tick while playing holds off further requests while
// it runs through the sum, setup, scan and flush states. The bit-serial tempo
// divider is used when the override is on and the original tempo is not zero.
// A second pass over the table is added when the position wraps. A tick with
// an empty loop returns to idle after the setup state, with no scan. The scan
// and the flush stall while the result register is full and not taken. The
// table is held in one RAM whose single read port sets the scan length. The
// table has no clearing pass: entries read before they are loaded give
// undefined data.
module looping_note_event_scheduler
   import lnes_pkg::*;
#(
   parameter int NOTE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ELAPSED_W-1:0]  req_elapsed_us,
   input  logic [INDEX_W-1:0]    req_entry_index,
   input  logic [TIME_MS_W-1:0]  req_entry_time_ms,
   input  logic [MSG_W-1:0]      req_entry_message,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MSG_W-1:0]      rsp_note_message,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW     = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
   localparam int CW     = $clog2(NOTE_DEPTH + 1);
   localparam int RAM_W  = TIME_US_W + MSG_W;
   localparam logic [CNT_W-1:0] DEPTH_LIMIT = CNT_W'(NOTE_DEPTH);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   lnes_state_type state_ff, state_in;

   logic [TIME_MS_W-1:0] loop_len_ff;
   logic [CNT_W-1:0]     note_cnt_ff;
   logic [BPM_W-1:0]     orig_bpm_ff;
   logic [BPM_W-1:0]     tempo_bpm_ff;
   logic                 tempo_ovr_ff;

   logic             playing_ff, playing_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] prev_ff, prev_in;
   logic             prev_neg_ff, prev_neg_in;

   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [BPM_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [TIME_US_W-1:0] len_ff, len_in;
   logic [POS_W-1:0]     upper_ff, upper_in;
   logic [POS_W-1:0]     new_pos_ff, new_pos_in;
   logic                 wrap_ff, wrap_in;
   logic                 pass_ff, pass_in;
   logic [CW-1:0]        scan_addr_ff, scan_addr_in;
   logic                 data_vld_ff, data_vld_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [MSG_W-1:0]     pend_msg_ff, pend_msg_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [MSG_W-1:0] rsp_msg_ff, rsp_msg_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                 ram_wr_en;
   logic [RAM_W-1:0]     ram_wr_data;
   logic                 ram_rd_en;
   logic [RAM_W-1:0]     ram_rd_data;
   logic [TIME_US_W-1:0] scan_time;
   logic [MSG_W-1:0]     scan_msg;
   logic [TIME_US_W-1:0] load_time;
   logic [PROD_W-1:0]    product;
   logic [CW-1:0]        active_cnt;
   logic                 out_free;
   logic                 hit;
   logic                 stall;
   logic                 push;
   logic                 push_last;
   logic [BPM_W:0]       trial;
   logic [POS_W:0]       pos_sum;

   assign load_time   = TIME_US_W'(req_entry_time_ms) * TIME_US_W'(US_PER_MS);
   assign ram_wr_data = {load_time, req_entry_message};
   assign product     = PROD_W'(req_elapsed_us) * PROD_W'(tempo_bpm_ff);
   assign scan_time   = ram_rd_data[RAM_W-1:MSG_W];
   assign scan_msg    = ram_rd_data[MSG_W-1:0];
   assign active_cnt  = (note_cnt_ff > DEPTH_LIMIT) ? CW'(NOTE_DEPTH) : note_cnt_ff[CW-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign trial       = {rem_ff, quo_ff[PROD_W-1]};
   assign pos_sum     = {1'b0, position_ff} + (POS_W + 1)'(quo_ff);

   always_comb begin
      if (!data_vld_ff) begin
         hit = 1'b0;
      end else if (pass_ff) begin
         hit = POS_W'(scan_time) <= new_pos_ff;
      end else begin
         hit = (prev_neg_ff || (prev_ff < POS_W'(scan_time))) && (POS_W'(scan_time) <= upper_ff);
      end
   end

   assign stall = hit && pend_vld_ff && !out_free;

   lnes_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NOTE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_addr_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      playing_in   = playing_ff;
      position_in  = position_ff;
      prev_in      = prev_ff;
      prev_neg_in  = prev_neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      upper_in     = upper_ff;
      new_pos_in   = new_pos_ff;
      wrap_in      = wrap_ff;
      pass_in      = pass_ff;
      scan_addr_in = scan_addr_ff;
      data_vld_in  = data_vld_ff;
      pend_vld_in  = pend_vld_ff;
      pend_msg_in  = pend_msg_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      push         = 1'b0;
      push_last    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_operation)
                  OP_START: begin
                     playing_in  = 1'b1;
                     position_in = '0;
                  end
                  OP_STOP: begin
                     playing_in  = 1'b0;
                     position_in = '0;
                     prev_in     = '0;
                     prev_neg_in = 1'b0;
                  end
                  OP_LOAD: begin
                     ram_wr_en = !playing_ff && ({1'b0, req_entry_index} < DEPTH_LIMIT);
                  end
                  OP_TICK: begin
                     if (playing_ff) begin
                        if (tempo_ovr_ff && (orig_bpm_ff != '0)) begin
                           quo_in     = product;
                           rem_in     = '0;
                           div_cnt_in = '0;
                           state_in   = ST_DIV;
                        end else begin
                           quo_in   = PROD_W'(req_elapsed_us);
                           state_in = ST_SUM;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, orig_bpm_ff}) begin
               rem_in = BPM_W'(trial - {1'b0, orig_bpm_ff});
               quo_in = {quo_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[BPM_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            pos_in   = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
            len_in   = TIME_US_W'(loop_len_ff) * TIME_US_W'(US_PER_MS);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (loop_len_ff == '0) begin
               position_in = '0;
               prev_in     = '0;
               prev_neg_in = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               wrap_in      = POS_W'(len_ff) < pos_ff;
               upper_in     = (pos_ff < POS_W'(len_ff)) ? pos_ff : POS_W'(len_ff);
               new_pos_in   = (POS_W'(len_ff) < pos_ff) ? pos_ff - POS_W'(len_ff) : pos_ff;
               pass_in      = 1'b0;
               scan_addr_in = '0;
               data_vld_in  = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  push        = pend_vld_ff;
                  pend_vld_in = 1'b1;
                  pend_msg_in = scan_msg;
               end
               if (scan_addr_ff < active_cnt) begin
                  ram_rd_en    = 1'b1;
                  scan_addr_in = scan_addr_ff + 1'b1;
                  data_vld_in  = 1'b1;
               end else begin
                  data_vld_in = 1'b0;
                  if (!data_vld_ff) begin
                     if (!pass_ff && wrap_ff) begin
                        pass_in      = 1'b1;
                        scan_addr_in = '0;
                     end else begin
                        state_in = ST_FLUSH;
                     end
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               push        = pend_vld_ff;
               push_last   = 1'b1;
               pend_vld_in = 1'b0;
               position_in = new_pos_ff;
               prev_in     = new_pos_ff;
               prev_neg_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_msg_in   = rsp_msg_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_msg_in   = pend_msg_ff;
         rsp_last_in  = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_len_ff  <= '0;
         note_cnt_ff  <= '0;
         orig_bpm_ff  <= BPM_W'(120);
         tempo_bpm_ff <= BPM_W'(120);
         tempo_ovr_ff <= 1'b0;
         playing_ff   <= 1'b0;
         position_ff  <= '0;
         prev_ff      <= '0;
         prev_neg_ff  <= 1'b1;
         div_cnt_ff   <= '0;
         pass_ff      <= 1'b0;
         scan_addr_ff <= '0;
         data_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         position_ff  <= position_in;
         prev_ff      <= prev_in;
         prev_neg_ff  <= prev_neg_in;
         div_cnt_ff   <= div_cnt_in;
         pass_ff      <= pass_in;
         scan_addr_ff <= scan_addr_in;
         data_vld_ff  <= data_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_LOOP_LENGTH:  loop_len_ff  <= csr_data[TIME_MS_W-1:0];
               CSR_NOTE_COUNT:   note_cnt_ff  <= csr_data[CNT_W-1:0];
               CSR_ORIGINAL_BPM: orig_bpm_ff  <= csr_data[BPM_W-1:0];
               CSR_TEMPO_BPM:    tempo_bpm_ff <= csr_data[BPM_W-1:0];
               CSR_TEMPO_OVR:    tempo_ovr_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      upper_ff    <= upper_in;
      new_pos_ff  <= new_pos_in;
      wrap_ff     <= wrap_in;
      pend_msg_ff <= pend_msg_in;
      rsp_msg_ff  <= rsp_msg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_note_message = rsp_msg_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("pending message left behind when the tick finished");

   a_data_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      data_vld_ff |-> (state_ff == ST_SCAN))
      else $error("table read data marked valid outside a scan");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_addr_ff <= active_cnt))
      else $error("scan address beyond the active note count");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) && pend_vld_ff && out_free) |=> (rsp_valid && rsp_last))
      else $error("final message of a tick not flagged as last");

   a_scan_no_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && push) |=> (rsp_valid && !rsp_last))
      else $error("message flagged as last before the tick finished");
`endif

endmodule
